/* sv/fpd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpd_pkg : shared types and constants
// Register indexes, widths and the lane handoff structs of the duty block.
// ---------------------------------------------------------------------------
package fpd_pkg;
    localparam int SUM_WIDTH = 48;
    localparam int PHASES    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUS_FLOOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_USE_MEAS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_BUS     = 3'd4;

    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};
    localparam logic [47:0]          ENERGY_MAX = {48{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

    // lane control from the sequencer
    typedef struct packed {
        logic        start;
        logic        acc_en;
        logic [16:0] bus;
        logic signed [34:0] mid;
    } t_lane_ctl;

    // lane status back to the merge stage
    typedef struct packed {
        logic        busy;
        logic        over;
        logic [15:0] duty;
    } t_lane_sts;
endpackage

/* sv/fpd_lane.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpd_lane : one phase lane
// Restoring divider for the duty, squared-current accumulator and limit test.
// ---------------------------------------------------------------------------
module fpd_lane
    import fpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_lane_ctl            i_ctl,
    input  logic signed [15:0]   i_cmd,
    input  logic signed [15:0]   i_amp,
    input  logic [14:0]          i_limit,
    output t_lane_sts            o_sts,
    output logic [SUM_WIDTH-1:0] o_sum
);
    // quotient of num / (2*bus) can exceed 16 bits; it is kept at QW bits until the saturation check
    localparam int QW = 36;

    logic [QW-1:0]        r_rem, n_rem;
    logic [QW-1:0]        r_quo, n_quo;
    logic [17:0]          r_den;
    logic [5:0]           r_cnt;
    logic                 r_busy;
    logic                 r_pos;
    logic [SUM_WIDTH-1:0] r_sum;
    logic [31:0]          r_sq;
    logic                 r_sq_en;
    logic signed [35:0]   w_num;
    logic [QW:0]          w_trial;
    logic [16:0]          w_abs;

    assign w_num   = 36'(signed'(i_cmd)) * 36'sd131072 + 36'(i_ctl.mid);
    assign w_trial = {r_rem[QW-1:0], r_quo[QW-1]} - {{(QW-17){1'b0}}, r_den};
    assign w_abs   = i_amp[15] ? 17'(-$signed({i_amp[15], i_amp})) : {1'b0, i_amp};

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        if (!w_trial[QW]) begin
            n_rem = w_trial[QW-1:0];
            n_quo = {r_quo[QW-2:0], 1'b1};
        end else begin
            n_rem = {r_rem[QW-2:0], r_quo[QW-1]};
            n_quo = {r_quo[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_sum   <= '0;
            r_sq_en <= 1'b0;
        end else begin
            r_sq_en <= i_ctl.start && i_ctl.acc_en;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(QW);
                r_rem  <= '0;
                r_quo  <= QW'(w_num);
                r_pos  <= (w_num > 0) && (i_ctl.bus != 0);
                r_den  <= {i_ctl.bus, 1'b0};
                r_sq   <= 32'($signed(i_amp) * $signed(i_amp));
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
            if (r_sq_en) begin
                if (r_sum > SUM_MAX - SUM_WIDTH'(r_sq)) begin
                    r_sum <= SUM_MAX;
                end else begin
                    r_sum <= r_sum + SUM_WIDTH'(r_sq);
                end
            end
        end
    end

    assign o_sts.busy = r_busy || r_sq_en;
    assign o_sts.over = w_abs > {2'b0, i_limit};
    assign o_sts.duty = !r_pos ? 16'd0 : (|r_quo[QW-1:16]) ? 16'hFFFF : r_quo[15:0];
    assign o_sum      = r_sum;
endmodule

/* sv/four_phase_pwm_duty_overcurrent.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// four_phase_pwm_duty_overcurrent : four-phase PWM duty with overcurrent trip
// Four lanes divide the phase commands by the bus; a merge stage applies trip.
// ---------------------------------------------------------------------------
// channel | signals                          | dir
// in      | i_valid/o_ready + 10 fields      | input
// out     | o_valid/i_ready + 11 fields      | output
// cfg     | i_cfg_we, i_cfg_idx, i_cfg_data  | input
// After the input transfer the item passes a prep state (midpoint vs cap), the
// steps of each lane's restoring divider and a merge that registers the duties.
// A tick held by an earlier trip skips the divider.
// Input ready returns once the result transfer has cleared o_valid and the FSM
// is back in idle. Reset is synchronous; config and control registers return to
// defaults, data registers are not reset. One item in flight.
module four_phase_pwm_duty_overcurrent
    import fpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_pulse_start,
    input  logic signed [15:0] i_volt_cmd_a,
    input  logic signed [15:0] i_volt_cmd_b,
    input  logic signed [15:0] i_volt_cmd_c,
    input  logic signed [15:0] i_volt_cmd_d,
    input  logic signed [15:0] i_amp_meas_a,
    input  logic signed [15:0] i_amp_meas_b,
    input  logic signed [15:0] i_amp_meas_c,
    input  logic signed [15:0] i_amp_meas_d,
    input  logic [15:0]        i_bus_meas,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_duty_a,
    output logic [15:0]        o_duty_b,
    output logic [15:0]        o_duty_c,
    output logic [15:0]        o_duty_d,
    output logic               o_tripped,
    output logic [47:0]        o_energy_a,
    output logic [47:0]        o_energy_b,
    output logic [47:0]        o_energy_c,
    output logic [47:0]        o_energy_d,
    output logic [15:0]        o_bus_low,
    output logic [15:0]        o_bus_high,
    input  logic               i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);
    logic [14:0] r_limit;
    logic [15:0] r_max_duty, r_floor, r_fixed;
    logic        r_use_meas;

    t_state r_state, n_state;
    logic signed [15:0] r_cmd [PHASES];
    logic signed [15:0] r_amp [PHASES];
    logic [15:0] r_bus_m;
    logic        r_pstart;
    logic [1:0]  r_ticks;
    logic        r_trip;
    logic [15:0] r_bmin, r_bmax;
    logic [16:0] r_bus;
    logic [32:0] r_cap;
    logic        r_live;
    logic [15:0] r_duty [PHASES];
    logic        r_ovalid;

    t_lane_ctl   w_ctl;
    t_lane_sts   w_sts [PHASES];
    logic [SUM_WIDTH-1:0] w_sum [PHASES];
    logic [47:0] w_energy [PHASES];
    logic signed [15:0] w_vmax;
    logic signed [34:0] w_mid;
    logic        w_accept, w_lanes_busy, w_any_over;
    logic [1:0]  w_ticks;
    logic        w_trip0;

    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= 15'd1000;
            r_max_duty <= 16'd62259;
            r_floor    <= 16'd0;
            r_use_meas <= 1'b1;
            r_fixed    <= 16'd15000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CURRENT_LIMIT: r_limit    <= i_cfg_data[14:0];
                REG_MAX_DUTY:      r_max_duty <= i_cfg_data;
                REG_BUS_FLOOR:     r_floor    <= i_cfg_data;
                REG_USE_MEAS:      r_use_meas <= i_cfg_data[0];
                REG_FIXED_BUS:     r_fixed    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_PREP;
            ST_PREP: n_state = ST_DIV;
            ST_DIV:  if (!w_lanes_busy) n_state = ST_DONE;
            ST_DONE: if (!r_ovalid) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE) && !r_ovalid;
    end

    // pulse start clears per-pulse state before the tick is evaluated
    assign w_ticks = r_pstart ? 2'd0 : r_ticks;
    assign w_trip0 = r_pstart ? 1'b0 : r_trip;

    always_comb begin
        w_vmax = r_cmd[0];
        for (int k = 1; k < PHASES; k++) begin
            if (r_cmd[k] > w_vmax) w_vmax = r_cmd[k];
        end
        w_mid = {2'b0, r_bus, 16'd0};
        if ($signed({2'b0, r_bus, 16'd0}) + 35'(w_vmax) * 35'sd131072
                > $signed({1'b0, r_cap, 1'b0})) begin
            w_mid = $signed({1'b0, r_cap, 1'b0}) - 35'(w_vmax) * 35'sd131072;
        end
    end

    assign w_ctl.start  = (r_state == ST_PREP) && !w_trip0;
    assign w_ctl.acc_en = w_ticks == 2'd2;
    assign w_ctl.bus    = r_bus;
    assign w_ctl.mid    = w_mid;

    always_comb begin
        w_lanes_busy = 1'b0;
        w_any_over   = 1'b0;
        for (int k = 0; k < PHASES; k++) begin
            w_lanes_busy = w_lanes_busy | w_sts[k].busy;
            w_any_over   = w_any_over | w_sts[k].over;
            w_energy[k]  = (w_sum[k] > SUM_WIDTH'(ENERGY_MAX)) ? ENERGY_MAX : 48'(w_sum[k]);
        end
    end

    for (genvar g = 0; g < PHASES; g++) begin : g_lane
        fpd_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_cmd   (r_cmd[g]),
            .i_amp   (r_amp[g]),
            .i_limit (r_limit),
            .o_sts   (w_sts[g]),
            .o_sum   (w_sum[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ticks  <= 2'd0;
            r_trip   <= 1'b0;
            r_bmin   <= 16'hFFFF;
            r_bmax   <= 16'd0;
            r_ovalid <= 1'b0;
            r_pstart <= 1'b0;
            r_live   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (w_accept) begin
                r_pstart <= i_pulse_start;
                r_bus_m  <= i_bus_meas;
                r_cmd[0] <= i_volt_cmd_a; r_cmd[1] <= i_volt_cmd_b;
                r_cmd[2] <= i_volt_cmd_c; r_cmd[3] <= i_volt_cmd_d;
                r_amp[0] <= i_amp_meas_a; r_amp[1] <= i_amp_meas_b;
                r_amp[2] <= i_amp_meas_c; r_amp[3] <= i_amp_meas_d;
                if (r_use_meas) begin
                    r_bus <= {1'b0, (i_bus_meas > r_floor) ? i_bus_meas : r_floor};
                    r_cap <= 33'(((i_bus_meas > r_floor) ? i_bus_meas : r_floor)
                                 * r_max_duty);
                end else begin
                    r_bus <= {1'b0, r_fixed};
                    r_cap <= 33'(r_fixed * r_max_duty);
                end
            end
            if (r_state == ST_PREP) begin
                r_live <= !w_trip0;
                r_trip <= w_trip0;
                if (r_pstart) begin
                    r_ticks <= 2'd0;
                    r_bmin  <= 16'hFFFF;
                    r_bmax  <= 16'd0;
                end
                if (!w_trip0) begin
                    if (r_use_meas) begin
                        if (r_bus_m > (r_pstart ? 16'd0 : r_bmax)) r_bmax <= r_bus_m;
                        if (r_bus_m < (r_pstart ? 16'hFFFF : r_bmin)) r_bmin <= r_bus_m;
                    end
                    if (w_any_over) begin
                        r_trip <= 1'b1;
                    end else if (w_ticks != 2'd2) begin
                        r_ticks <= w_ticks + 2'd1;
                    end
                end
            end
            if (r_state == ST_DIV && !w_lanes_busy) begin
                for (int k = 0; k < PHASES; k++) begin
                    r_duty[k] <= (r_live && !r_trip) ? w_sts[k].duty : 16'd0;
                end
                r_ovalid <= 1'b1;
            end
        end
    end

    assign o_valid    = r_ovalid;
    assign o_duty_a   = r_duty[0];
    assign o_duty_b   = r_duty[1];
    assign o_duty_c   = r_duty[2];
    assign o_duty_d   = r_duty[3];
    assign o_tripped  = r_trip;
    assign o_energy_a = w_energy[0];
    assign o_energy_b = w_energy[1];
    assign o_energy_c = w_energy[2];
    assign o_energy_d = w_energy[3];
    assign o_bus_low  = r_bmin;
    assign o_bus_high = r_bmax;
endmodule

/* sv/fpd_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fpd_checker : port-level checks
// Watches transfers and trip behavior on the top-level ports.
// ---------------------------------------------------------------------------
module fpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_tripped,
    input logic [15:0] o_duty_a,
    input logic [15:0] o_duty_b,
    input logic [15:0] o_duty_c,
    input logic [15:0] o_duty_d
);
    a_trip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tripped |-> (o_duty_a | o_duty_b | o_duty_c | o_duty_d) == 16'd0)
        else $error("duty nonzero while tripped");

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while result pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_duty_a) && $stable(o_tripped))
        else $error("result changed while stalled");

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second transfer accepted too soon");
endmodule

bind four_phase_pwm_duty_overcurrent fpd_checker u_fpd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_tripped (o_tripped),
    .o_duty_a  (o_duty_a),
    .o_duty_b  (o_duty_b),
    .o_duty_c  (o_duty_c),
    .o_duty_d  (o_duty_d)
);
